// ===== design/dcmb_pkg.sv =====
// ----------------------------------------------------------------------------
// dcmb_pkg
// Types and address constants shared by the dual CPU mailbox I/O block.
// ----------------------------------------------------------------------------
`default_nettype none

package dcmb_pkg;

   // Bus access kinds
   typedef enum logic [1:0] {
      OP_MAIN_RD = 2'd0,
      OP_MAIN_WR = 2'd1,
      OP_SND_RD  = 2'd2,
      OP_SND_WR  = 2'd3
   } op_type;

   localparam int unsigned ADDR_W     = 24;
   localparam int unsigned DATA_W     = 16;
   localparam int unsigned BYTE_W     = 8;
   // Store index is taken from address bits 11:1 before wrapping
   localparam int unsigned RAW_IDX_W  = 11;

   // Main side map
   localparam logic [11:0] MAIN_NV_PAGE   = 12'h802;
   localparam logic [23:0] MAIN_STATUS    = 24'h803008;
   localparam logic [23:0] MAIN_MBOX_RD   = 24'h80300e;
   localparam logic [23:0] MAIN_VB_ACK    = 24'h803140;
   localparam logic [23:0] MAIN_NV_UNLOCK = 24'h803150;
   localparam logic [23:0] MAIN_MBOX_WR   = 24'h803170;
   localparam logic [19:0] MAIN_SND_RESET = 20'h80312;
   localparam logic [15:0] MAIN_STATUS_BASE = 16'hff87;

   // Sound side map, address bits 15:4
   localparam logic [11:0] SND_MBOX_WR  = 12'h100;
   localparam logic [11:0] SND_MBOX_RD  = 12'h101;
   localparam logic [11:0] SND_MIXER    = 12'h102;
   localparam logic [11:0] SND_LATCH    = 12'h103;
   localparam logic [11:0] SND_IRQ_ACK  = 12'h183;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   address;
      logic [DATA_W-1:0]   wdata;
      logic                vblank_active;
      logic                speech_busy;
   } item_type;

   typedef struct packed {
      logic [DATA_W-1:0]   read_data;
      logic                main_irq_level;
      logic                sound_nmi_level;
      logic                sound_halted;
      logic                sound_restart;
      logic                fm_reset;
      logic [BYTE_W-1:0]   sound_control;
      logic [BYTE_W-1:0]   mixer_levels;
      logic                vblank_irq_ack;
      logic                sound_irq_ack;
   } result_type;

   // Store write request from the access logic
   typedef struct packed {
      logic                 en;
      logic [RAW_IDX_W-1:0] raw_idx;
      logic [BYTE_W-1:0]    data;
   } store_wr_type;

endpackage

`default_nettype wire

// ===== design/dcmb_nvram.sv =====
// ----------------------------------------------------------------------------
// dcmb_nvram
// Byte-wide nonvolatile store: one write port, one registered read port,
// and a clearing pass to all ones after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmb_nvram #(
   parameter int unsigned NVRAM_DEPTH = 2048
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rd_en,
   input  wire logic [dcmb_pkg::RAW_IDX_W-1:0] rd_raw_idx,
   input  wire dcmb_pkg::store_wr_type        wr,
   output logic [dcmb_pkg::BYTE_W-1:0]        rd_data,
   output logic                               clearing
);

   localparam int unsigned IdxW = $clog2(NVRAM_DEPTH);

   logic [dcmb_pkg::BYTE_W-1:0] mem [NVRAM_DEPTH];
   logic [IdxW-1:0]             clear_idx_ff, clear_idx_in;
   logic                        clearing_ff, clearing_in;
   logic [dcmb_pkg::BYTE_W-1:0] rd_data_ff;
   logic [IdxW-1:0]             rd_idx, wr_idx, mem_waddr;
   logic [dcmb_pkg::BYTE_W-1:0] mem_wdata;
   logic                        mem_we;

   // Wrap the raw index into the store depth by conditional subtraction
   function automatic logic [IdxW-1:0] wrap_idx(input logic [dcmb_pkg::RAW_IDX_W-1:0] raw);
      logic [dcmb_pkg::RAW_IDX_W-1:0] rem;
      rem = raw;
      for (int k = 3; k >= 0; k--) begin
         if (32'(rem) >= (NVRAM_DEPTH << k)) begin
            rem = rem - dcmb_pkg::RAW_IDX_W'(NVRAM_DEPTH << k);
         end
      end
      return IdxW'(rem);
   endfunction

   assign rd_idx = wrap_idx(rd_raw_idx);
   assign wr_idx = wrap_idx(wr.raw_idx);

   always_comb begin
      clear_idx_in = clear_idx_ff;
      clearing_in  = clearing_ff;
      if (clearing_ff) begin
         if (clear_idx_ff == IdxW'(NVRAM_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clear_idx_in = clear_idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clear_idx_ff;
         mem_wdata = '1;
      end else begin
         mem_we    = wr.en;
         mem_waddr = wr_idx;
         mem_wdata = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_idx_ff <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_idx_ff <= clear_idx_in;
      end
   end

   // Write-first: a read of the entry written in the same cycle sees new data
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         if (mem_we && (mem_waddr == rd_idx)) begin
            rd_data_ff <= mem_wdata;
         end else begin
            rd_data_ff <= mem[rd_idx];
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

`default_nettype wire

// ===== design/dcmb_core.sv =====
// ----------------------------------------------------------------------------
// dcmb_core
// Mailbox, status, unlock, sound reset, control latch and mixer state, with
// the decode of one bus access into the next state and its result.
// ----------------------------------------------------------------------------
`default_nettype none

module dcmb_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire dcmb_pkg::item_type          item,
   input  wire logic [dcmb_pkg::BYTE_W-1:0] store_rd_data,
   input  wire logic                        self_test,
   output dcmb_pkg::result_type             result,
   output dcmb_pkg::store_wr_type           store_wr
);

   logic                        to_sound_full_ff, to_sound_full_in;
   logic                        to_main_full_ff,  to_main_full_in;
   logic [dcmb_pkg::BYTE_W-1:0] to_sound_byte_ff, to_sound_byte_in;
   logic [dcmb_pkg::BYTE_W-1:0] to_main_byte_ff,  to_main_byte_in;
   logic                        reset_line_ff,    reset_line_in;
   logic                        halted_ff,        halted_in;
   logic                        unlock_ff,        unlock_in;
   logic [dcmb_pkg::BYTE_W-1:0] latch_ff,         latch_in;
   logic [dcmb_pkg::BYTE_W-1:0] mixer_ff,         mixer_in;

   logic [dcmb_pkg::ADDR_W-1:0] a;
   logic [15:0]                 s;
   logic [dcmb_pkg::BYTE_W-1:0] v;
   logic [dcmb_pkg::DATA_W-1:0] rd;
   logic                        restart, fmres, vack, sack;

   assign a = item.address;
   assign s = item.address[15:0];
   assign v = item.wdata[dcmb_pkg::BYTE_W-1:0];

   always_comb begin
      to_sound_full_in = to_sound_full_ff;
      to_main_full_in  = to_main_full_ff;
      to_sound_byte_in = to_sound_byte_ff;
      to_main_byte_in  = to_main_byte_ff;
      reset_line_in    = reset_line_ff;
      halted_in        = halted_ff;
      unlock_in        = unlock_ff;
      latch_in         = latch_ff;
      mixer_in         = mixer_ff;
      rd               = '0;
      restart          = 1'b0;
      fmres            = 1'b0;
      vack             = 1'b0;
      sack             = 1'b0;
      store_wr.en      = 1'b0;
      store_wr.raw_idx = a[dcmb_pkg::RAW_IDX_W:1];
      store_wr.data    = v;

      unique case (item.op)
         dcmb_pkg::OP_MAIN_RD: begin
            if (a[23:12] == dcmb_pkg::MAIN_NV_PAGE) begin
               rd = {8'hff, store_rd_data};
            end else if (a == dcmb_pkg::MAIN_STATUS) begin
               rd = dcmb_pkg::MAIN_STATUS_BASE
                  | {9'b0, item.vblank_active, to_sound_full_ff, to_main_full_ff,
                     self_test, 3'b0};
            end else if (a == dcmb_pkg::MAIN_MBOX_RD) begin
               to_main_full_in = 1'b0;
               rd = {8'hff, to_main_byte_ff};
            end else begin
               rd = '1;
            end
         end
         dcmb_pkg::OP_MAIN_WR: begin
            if (a[23:12] == dcmb_pkg::MAIN_NV_PAGE) begin
               if (unlock_ff) begin
                  store_wr.en = 1'b1;
                  unlock_in   = 1'b0;
               end
            end else if (a == dcmb_pkg::MAIN_VB_ACK) begin
               vack = 1'b1;
            end else if (a == dcmb_pkg::MAIN_NV_UNLOCK) begin
               unlock_in = 1'b1;
            end else if (a == dcmb_pkg::MAIN_MBOX_WR) begin
               to_sound_byte_in = v;
               to_sound_full_in = 1'b1;
            end else if ((a[23:4] == dcmb_pkg::MAIN_SND_RESET) && (a[3:0] != 4'hf)) begin
               // Act on edges of the reset line only
               if (item.wdata[0] != reset_line_ff) begin
                  reset_line_in   = item.wdata[0];
                  halted_in       = ~item.wdata[0];
                  restart         = item.wdata[0];
                  to_main_full_in = 1'b0;
               end
            end
         end
         dcmb_pkg::OP_SND_RD: begin
            if (s[15:4] == dcmb_pkg::SND_MBOX_RD) begin
               to_sound_full_in = 1'b0;
               rd = {8'h00, to_sound_byte_ff};
            end else if (s[15:4] == dcmb_pkg::SND_LATCH) begin
               rd = {8'h00, to_sound_full_ff, to_main_full_ff, item.speech_busy,
                     ~self_test, 4'b0};
            end else if (s[15:4] == dcmb_pkg::SND_IRQ_ACK) begin
               sack = 1'b1;
            end else begin
               rd = 16'h00ff;
            end
         end
         dcmb_pkg::OP_SND_WR: begin
            if (s[15:4] == dcmb_pkg::SND_MBOX_WR) begin
               to_main_byte_in = v;
               to_main_full_in = 1'b1;
            end else if (s[15:4] == dcmb_pkg::SND_MIXER) begin
               mixer_in = v;
            end else if (s[15:4] == dcmb_pkg::SND_LATCH) begin
               latch_in[s[2:0]] = v[7];
               fmres = ~v[7] && (s[2:0] == 3'd0);
            end else if (s[15:4] == dcmb_pkg::SND_IRQ_ACK) begin
               sack = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (!advance) begin
         store_wr.en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         to_sound_full_ff <= 1'b0;
         to_main_full_ff  <= 1'b0;
         to_sound_byte_ff <= '0;
         to_main_byte_ff  <= '0;
         reset_line_ff    <= 1'b1;
         halted_ff        <= 1'b0;
         unlock_ff        <= 1'b0;
         latch_ff         <= '1;
         mixer_ff         <= '0;
      end else if (advance) begin
         to_sound_full_ff <= to_sound_full_in;
         to_main_full_ff  <= to_main_full_in;
         to_sound_byte_ff <= to_sound_byte_in;
         to_main_byte_ff  <= to_main_byte_in;
         reset_line_ff    <= reset_line_in;
         halted_ff        <= halted_in;
         unlock_ff        <= unlock_in;
         latch_ff         <= latch_in;
         mixer_ff         <= mixer_in;
      end
   end

   always_comb begin
      result.read_data       = rd;
      result.main_irq_level  = to_main_full_in;
      result.sound_nmi_level = to_sound_full_in;
      result.sound_halted    = halted_in;
      result.sound_restart   = restart;
      result.fm_reset        = fmres;
      result.sound_control   = latch_in;
      result.mixer_levels    = mixer_in;
      result.vblank_irq_ack  = vack;
      result.sound_irq_ack   = sack;
   end

endmodule

`default_nettype wire

// ===== design/dual_cpu_mailbox_io_block_top.sv =====
// ----------------------------------------------------------------------------
// dual_cpu_mailbox_io_block_top
// I/O glue between a main CPU and a sound CPU: two mailboxes, status bytes,
// sound reset and control latch, mixer byte and a write-unlocked store.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | carries
//   --------+-----------+--------------------+-------------------------------
//   req_    | in        | req_valid/ready    | one bus access (op, address..)
//   rsp_    | out       | rsp_valid/ready    | read data, levels, pulses
//   csr_    | in        | csr_valid/ready    | self-test switch
//
// One transaction is accepted per cycle while req_ready is high; an accepted
// access passes the input register (with the store read) and then the result
// register, and rsp_valid rises when it lands in the result register.
// The store read is issued at acceptance so the decode stage sees its data.
// After reset the store is swept to all ones, one entry a cycle; req_ready
// stays low meanwhile, csr writes are taken. A stalled result holds the decode
// stage, which in turn drops req_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_cpu_mailbox_io_block_top #(
   parameter int unsigned NVRAM_DEPTH = 2048
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // access transactions
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [23:0] req_address,
   input  wire logic [15:0] req_wdata,
   input  wire logic        req_vblank_active,
   input  wire logic        req_speech_busy,
   // result transactions
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_read_data,
   output logic             rsp_main_irq_level,
   output logic             rsp_sound_nmi_level,
   output logic             rsp_sound_halted,
   output logic             rsp_sound_restart,
   output logic             rsp_fm_reset,
   output logic [7:0]       rsp_sound_control,
   output logic [7:0]       rsp_mixer_levels,
   output logic             rsp_vblank_irq_ack,
   output logic             rsp_sound_irq_ack,
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_self_test_switch
);

   logic                   s1_valid_ff, s1_valid_in;
   dcmb_pkg::item_type     s1_item_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   dcmb_pkg::result_type   rsp_ff;
   logic                   self_test_ff;

   logic                   req_take, s1_move, clearing;
   logic [7:0]             store_rd_data;
   dcmb_pkg::result_type   s1_result;
   dcmb_pkg::store_wr_type store_wr;

   // Decode stage advances when the result register is free or being taken
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clearing && (!s1_valid_ff || s1_move);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         self_test_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            self_test_ff <= csr_self_test_switch;
         end
      end
   end

   // Payload registers: hold until the next transaction moves in
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.op            <= dcmb_pkg::op_type'(req_op);
         s1_item_ff.address       <= req_address;
         s1_item_ff.wdata         <= req_wdata;
         s1_item_ff.vblank_active <= req_vblank_active;
         s1_item_ff.speech_busy   <= req_speech_busy;
      end
      if (s1_move) begin
         rsp_ff <= s1_result;
      end
   end

   dcmb_nvram #(
      .NVRAM_DEPTH (NVRAM_DEPTH)
   ) u_nvram (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_take),
      .rd_raw_idx (req_address[dcmb_pkg::RAW_IDX_W:1]),
      .wr         (store_wr),
      .rd_data    (store_rd_data),
      .clearing   (clearing)
   );

   dcmb_core u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (s1_move),
      .item          (s1_item_ff),
      .store_rd_data (store_rd_data),
      .self_test     (self_test_ff),
      .result        (s1_result),
      .store_wr      (store_wr)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rsp_ff.read_data;
   assign rsp_main_irq_level  = rsp_ff.main_irq_level;
   assign rsp_sound_nmi_level = rsp_ff.sound_nmi_level;
   assign rsp_sound_halted    = rsp_ff.sound_halted;
   assign rsp_sound_restart   = rsp_ff.sound_restart;
   assign rsp_fm_reset        = rsp_ff.fm_reset;
   assign rsp_sound_control   = rsp_ff.sound_control;
   assign rsp_mixer_levels    = rsp_ff.mixer_levels;
   assign rsp_vblank_irq_ack  = rsp_ff.vblank_irq_ack;
   assign rsp_sound_irq_ack   = rsp_ff.sound_irq_ack;

endmodule

`default_nettype wire
